// ===== rtl/lsp_pkg.sv =====
`default_nettype none

package lsp_pkg;

    localparam int DEF_SENSOR_COUNT = 16;
    localparam int DEF_SAMPLE_BITS  = 10;

    localparam int CMD_W   = 2;
    localparam int IDX_W   = 4;
    localparam int SMP_W   = 10;
    localparam int RANGE_W = 10;
    localparam int THR_W   = 12;
    localparam int MIN_W   = 13;
    localparam int SUM_W   = 14;
    localparam int CNT_W   = 5;
    localparam int RAW_W   = 11;
    localparam int SCL_W   = 12;
    localparam int MASK_W  = 16;
    localparam int WGT_W   = 11;
    localparam int PROD_W  = 24;

    localparam int QUEUE_DEPTH = 2;

    // serial divider operand widths
    localparam int DIV_N_W = 22;
    localparam int DIV_D_W = 11;

    localparam int POS_STEP     = 100;
    localparam int POS_LOW      = 100;
    localparam int POS_HIGH     = 1600;
    localparam int POS_SPAN     = POS_HIGH - POS_LOW;
    localparam int CAL_MIN_INIT = 5000;
    localparam int RANGE_RESET  = 100;

    // divide by POS_SPAN as a multiply by the rounded-up reciprocal and a shift;
    // exact for every dividend below 2**22
    localparam int SCL_SHIFT   = 33;
    localparam int SCL_RECIP_W = 23;
    localparam logic [SCL_RECIP_W-1:0] SCL_RECIP =
        SCL_RECIP_W'(((64'd1 << SCL_SHIFT) + 64'(POS_SPAN) - 64'd1) / 64'(POS_SPAN));

    typedef enum logic [CMD_W-1:0] {
        CMD_MEASURE    = 2'd0,
        CMD_CAL_START  = 2'd1,
        CMD_CAL_SAMPLE = 2'd2,
        CMD_CAL_FINISH = 2'd3
    } lsp_cmd_t;

    typedef struct packed {
        lsp_cmd_t           kind;
        logic               idx_ok;
        logic [IDX_W-1:0]   idx;
        logic [SMP_W-1:0]   smp;
        logic               last;
    } lsp_item_t;

    typedef struct packed {
        logic               start;
        logic [DIV_N_W-1:0] dividend;
        logic [DIV_D_W-1:0] divisor;
    } lsp_div_req_t;

    typedef struct packed {
        logic               done;
        logic [DIV_N_W-1:0] quotient;
    } lsp_div_rsp_t;

    // position weight of a sensor: (index + 1) * 100
    function automatic logic [WGT_W-1:0] lsp_weight(input logic [IDX_W-1:0] idx);
        logic [WGT_W-1:0] base;
        base = WGT_W'(idx) + WGT_W'(1);
        return WGT_W'(base * WGT_W'(POS_STEP));
    endfunction

endpackage

`default_nettype wire

// ===== rtl/line_sensor_position_unit.sv =====
`default_nettype none

// Line bar position unit. Transactions enter through a two-entry queue and are
// executed one at a time. Calibration-sample, calibration-start and measure
// transactions that do not close a scan finish in the cycle they are popped, so
// back-to-back input flows at one per cycle while no walk or scan close is busy.
// Calibration finish walks the threshold table one sensor per cycle. A measure
// transaction that closes a scan with hits runs the 22-step serial divider for
// the average, then, for the scaling, a registered multiply, a reciprocal
// multiply and a sign and range adjustment; without hits the divider is skipped.
// The result waits for a free output register. No clearing pass after reset.
module line_sensor_position_unit #(
    parameter int SENSOR_COUNT = lsp_pkg::DEF_SENSOR_COUNT,
    parameter int SAMPLE_BITS  = lsp_pkg::DEF_SAMPLE_BITS
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_write,
    input  wire logic [lsp_pkg::RANGE_W-1:0]   cfg_data,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [lsp_pkg::CMD_W-1:0]     command,
    input  wire logic [lsp_pkg::IDX_W-1:0]     sensor_index,
    input  wire logic [lsp_pkg::SMP_W-1:0]     sample,
    input  wire logic                          last_in_scan,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [lsp_pkg::RAW_W-1:0]          raw_position,
    output logic signed [lsp_pkg::SCL_W-1:0]   scaled_position,
    output logic                               line_seen,
    output logic [lsp_pkg::MASK_W-1:0]         hit_mask
);
    import lsp_pkg::*;

    lsp_item_t push_item;
    lsp_item_t head_item;
    logic      q_push, q_full, q_pop, q_empty;

    lsp_front #(
        .SENSOR_COUNT (SENSOR_COUNT),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_front (
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .command      (command),
        .sensor_index (sensor_index),
        .sample       (sample),
        .last_in_scan (last_in_scan),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_item       (push_item)
    );

    lsp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .head      (head_item),
        .empty     (q_empty)
    );

    lsp_back #(
        .SENSOR_COUNT (SENSOR_COUNT)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_data        (cfg_data),
        .q_head          (head_item),
        .q_empty         (q_empty),
        .q_pop           (q_pop),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .raw_position    (raw_position),
        .scaled_position (scaled_position),
        .line_seen       (line_seen),
        .hit_mask        (hit_mask)
    );

endmodule

`default_nettype wire

// ===== rtl/lsp_front.sv =====
`default_nettype none

module lsp_front #(
    parameter int SENSOR_COUNT = lsp_pkg::DEF_SENSOR_COUNT,
    parameter int SAMPLE_BITS  = lsp_pkg::DEF_SAMPLE_BITS
) (
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic [lsp_pkg::CMD_W-1:0] command,
    input  wire logic [lsp_pkg::IDX_W-1:0] sensor_index,
    input  wire logic [lsp_pkg::SMP_W-1:0] sample,
    input  wire logic                      last_in_scan,
    input  wire logic                      q_full,
    output logic                           q_push,
    output lsp_pkg::lsp_item_t             q_item
);
    import lsp_pkg::*;

    localparam int KEEP_BITS = (SAMPLE_BITS < SMP_W) ? SAMPLE_BITS : SMP_W;
    localparam logic [SMP_W-1:0] SMP_KEEP = SMP_W'((1 << KEEP_BITS) - 1);

    lsp_cmd_t kind;

    assign kind     = lsp_cmd_t'(command);
    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full;

    always_comb
    begin
        q_item.kind   = kind;
        q_item.idx_ok = ({1'b0, sensor_index} < (IDX_W + 1)'(SENSOR_COUNT));
        q_item.idx    = sensor_index;
        q_item.smp    = sample & SMP_KEEP;
        // the scan marker only matters on a measure sample
        q_item.last   = last_in_scan && (kind == CMD_MEASURE);
    end

endmodule

`default_nettype wire

// ===== rtl/lsp_queue.sv =====
`default_nettype none

module lsp_queue #(
    parameter int DEPTH = lsp_pkg::QUEUE_DEPTH
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire lsp_pkg::lsp_item_t push_item,
    output logic                    full,
    input  wire logic               pop,
    output lsp_pkg::lsp_item_t      head,
    output logic                    empty
);
    import lsp_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W_Q = $clog2(DEPTH + 1);

    lsp_item_t            store_reg [DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CNT_W_Q-1:0]   cnt_reg, cnt_next;
    logic                 do_push, do_pop;

    assign full    = (cnt_reg == CNT_W_Q'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign head    = store_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_reg + 1'b1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_reg + 1'b1);
        end
        if (do_push && !do_pop)
        begin
            cnt_next = CNT_W_Q'(cnt_reg + 1'b1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = CNT_W_Q'(cnt_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/lsp_div.sv =====
`default_nettype none

module lsp_div (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire lsp_pkg::lsp_div_req_t req,
    output lsp_pkg::lsp_div_rsp_t rsp
);
    import lsp_pkg::*;

    localparam int STEP_W = $clog2(DIV_N_W);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [STEP_W-1:0]    step_reg, step_next;
    logic [DIV_N_W-1:0]   quo_reg, quo_next;
    logic [DIV_D_W:0]     rem_reg, rem_next;
    logic [DIV_D_W-1:0]   dvs_reg, dvs_next;
    logic [DIV_D_W:0]     rem_sh;
    logic                 fits;

    // one quotient bit per cycle, restoring
    assign rem_sh = {rem_reg[DIV_D_W-1:0], quo_reg[DIV_N_W-1]};
    assign fits   = (rem_sh >= {1'b0, dvs_reg});

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            step_next = STEP_W'(DIV_N_W - 1);
            quo_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[DIV_N_W-2:0], fits};
            rem_next = fits ? (DIV_D_W + 1)'(rem_sh - {1'b0, dvs_reg}) : rem_sh;
            if (step_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                step_next = STEP_W'(step_reg - 1'b1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

endmodule

`default_nettype wire

// ===== rtl/lsp_back.sv =====
`default_nettype none

module lsp_back #(
    parameter int SENSOR_COUNT = lsp_pkg::DEF_SENSOR_COUNT
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_write,
    input  wire logic [lsp_pkg::RANGE_W-1:0] cfg_data,
    input  wire lsp_pkg::lsp_item_t          q_head,
    input  wire logic                        q_empty,
    output logic                             q_pop,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [lsp_pkg::RAW_W-1:0]        raw_position,
    output logic signed [lsp_pkg::SCL_W-1:0] scaled_position,
    output logic                             line_seen,
    output logic [lsp_pkg::MASK_W-1:0]       hit_mask
);
    import lsp_pkg::*;

    localparam int SI_W = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK,
        ST_DIV_AVG,
        ST_MUL,
        ST_SCL_GO,
        ST_SCL_ADJ,
        ST_EMIT
    } state_t;

    state_t                   state_reg, state_next;
    logic [RANGE_W-1:0]       range_reg, range_next;
    logic [THR_W-1:0]         thr_reg [SENSOR_COUNT];
    logic [THR_W-1:0]         thr_next [SENSOR_COUNT];
    logic [MIN_W-1:0]         min_reg [SENSOR_COUNT];
    logic [MIN_W-1:0]         min_next [SENSOR_COUNT];
    logic [SMP_W-1:0]         max_reg [SENSOR_COUNT];
    logic [SMP_W-1:0]         max_next [SENSOR_COUNT];
    logic [SUM_W-1:0]         sum_reg, sum_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic [SENSOR_COUNT-1:0]  scan_mask_reg, scan_mask_next;
    logic [RAW_W-1:0]         held_reg, held_next;
    logic [SI_W-1:0]          walk_reg, walk_next;

    logic [RAW_W-1:0]         res_raw_reg, res_raw_next;
    logic                     res_seen_reg, res_seen_next;
    logic [SENSOR_COUNT-1:0]  res_mask_reg, res_mask_next;
    logic [SCL_W-1:0]         res_scl_reg, res_scl_next;
    logic [PROD_W-1:0]        prod_reg, prod_next;
    logic                     neg_reg, neg_next;
    logic [SCL_W-1:0]         scl_quo_reg, scl_quo_next;

    logic                     out_valid_reg, out_valid_next;
    logic [RAW_W-1:0]         out_raw_reg, out_raw_next;
    logic [SCL_W-1:0]         out_scl_reg, out_scl_next;
    logic                     out_seen_reg, out_seen_next;
    logic [MASK_W-1:0]        out_mask_reg, out_mask_next;

    lsp_div_req_t             div_req;
    lsp_div_rsp_t             div_rsp;

    logic [SI_W-1:0]          idx_a;
    logic                     hit;
    logic [SUM_W-1:0]         sum_upd;
    logic [CNT_W-1:0]         cnt_upd;
    logic [SENSOR_COUNT-1:0]  mask_upd;
    logic [RAW_W-1:0]         mul_mag;
    logic [PROD_W-1:0]        prod_full;
    logic [PROD_W+SCL_RECIP_W-1:0] recip_prod;
    logic [SCL_W-1:0]         quo_s, quo_signed;
    logic [MIN_W:0]           mid_sum;

    lsp_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign idx_a = q_head.idx[SI_W-1:0];
    assign hit   = q_head.idx_ok
                   && (THR_W'(q_head.smp) > thr_reg[idx_a])
                   && !scan_mask_reg[idx_a];

    always_comb
    begin
        sum_upd  = sum_reg;
        cnt_upd  = cnt_reg;
        mask_upd = scan_mask_reg;
        if (hit)
        begin
            sum_upd         = SUM_W'(sum_reg + SUM_W'(lsp_weight(q_head.idx)));
            cnt_upd         = CNT_W'(cnt_reg + 1'b1);
            mask_upd[idx_a] = 1'b1;
        end
    end

    // |raw - 100| * 2R, divided by 1500, with the sign restored afterwards
    assign mul_mag    = (res_raw_reg >= RAW_W'(POS_LOW))
                        ? RAW_W'(res_raw_reg - RAW_W'(POS_LOW))
                        : RAW_W'(RAW_W'(POS_LOW) - res_raw_reg);
    assign prod_full  = PROD_W'(mul_mag) * PROD_W'({range_reg, 1'b0});
    assign recip_prod = (PROD_W + SCL_RECIP_W)'(prod_reg)
                        * (PROD_W + SCL_RECIP_W)'(SCL_RECIP);
    assign quo_s      = recip_prod[SCL_SHIFT +: SCL_W];
    assign quo_signed = neg_reg ? SCL_W'(-scl_quo_reg) : scl_quo_reg;
    assign mid_sum   = (MIN_W + 1)'(min_reg[walk_reg]) + (MIN_W + 1)'(max_reg[walk_reg]);

    always_comb
    begin
        state_next     = state_reg;
        range_next     = cfg_write ? cfg_data : range_reg;
        thr_next       = thr_reg;
        min_next       = min_reg;
        max_next       = max_reg;
        sum_next       = sum_reg;
        cnt_next       = cnt_reg;
        scan_mask_next = scan_mask_reg;
        held_next      = held_reg;
        walk_next      = walk_reg;
        res_raw_next   = res_raw_reg;
        res_seen_next  = res_seen_reg;
        res_mask_next  = res_mask_reg;
        res_scl_next   = res_scl_reg;
        prod_next      = prod_reg;
        neg_next       = neg_reg;
        scl_quo_next   = scl_quo_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_raw_next   = out_raw_reg;
        out_scl_next   = out_scl_reg;
        out_seen_next  = out_seen_reg;
        out_mask_next  = out_mask_reg;
        div_req        = '0;
        q_pop          = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop = 1'b1;
                    case (q_head.kind)
                        CMD_CAL_START:
                        begin
                            for (int i = 0; i < SENSOR_COUNT; i++)
                            begin
                                min_next[i] = MIN_W'(CAL_MIN_INIT);
                                max_next[i] = '0;
                            end
                        end
                        CMD_CAL_SAMPLE:
                        begin
                            if (q_head.idx_ok)
                            begin
                                if (min_reg[idx_a] > MIN_W'(q_head.smp))
                                begin
                                    min_next[idx_a] = MIN_W'(q_head.smp);
                                end
                                if (max_reg[idx_a] < q_head.smp)
                                begin
                                    max_next[idx_a] = q_head.smp;
                                end
                            end
                        end
                        CMD_CAL_FINISH:
                        begin
                            walk_next  = '0;
                            state_next = ST_WALK;
                        end
                        default:
                        begin
                            sum_next       = sum_upd;
                            cnt_next       = cnt_upd;
                            scan_mask_next = mask_upd;
                            if (q_head.last)
                            begin
                                // close the scan: latch result fields, clear accumulators
                                res_seen_next  = (cnt_upd != '0);
                                res_mask_next  = mask_upd;
                                sum_next       = '0;
                                cnt_next       = '0;
                                scan_mask_next = '0;
                                if (cnt_upd != '0)
                                begin
                                    div_req.start    = 1'b1;
                                    div_req.dividend = DIV_N_W'(sum_upd);
                                    div_req.divisor  = DIV_D_W'(cnt_upd);
                                    state_next       = ST_DIV_AVG;
                                end
                                else
                                begin
                                    res_raw_next = held_reg;
                                    state_next   = ST_MUL;
                                end
                            end
                        end
                    endcase
                end
            end
            ST_WALK:
            begin
                thr_next[walk_reg] = THR_W'(mid_sum >> 1);
                if (walk_reg == SI_W'(SENSOR_COUNT - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    walk_next = SI_W'(walk_reg + 1'b1);
                end
            end
            ST_DIV_AVG:
            begin
                if (div_rsp.done)
                begin
                    held_next    = div_rsp.quotient[RAW_W-1:0];
                    res_raw_next = div_rsp.quotient[RAW_W-1:0];
                    state_next   = ST_MUL;
                end
            end
            ST_MUL:
            begin
                prod_next  = prod_full;
                neg_next   = (res_raw_reg < RAW_W'(POS_LOW));
                state_next = ST_SCL_GO;
            end
            ST_SCL_GO:
            begin
                scl_quo_next = quo_s;
                state_next   = ST_SCL_ADJ;
            end
            ST_SCL_ADJ:
            begin
                res_scl_next = SCL_W'(quo_signed - SCL_W'(range_reg));
                state_next   = ST_EMIT;
            end
            ST_EMIT:
            begin
                // hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_raw_next   = res_raw_reg;
                    out_scl_next   = res_scl_reg;
                    out_seen_next  = res_seen_reg;
                    out_mask_next  = MASK_W'(res_mask_reg);
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            range_reg     <= RANGE_W'(RANGE_RESET);
            for (int i = 0; i < SENSOR_COUNT; i++)
            begin
                thr_reg[i] <= '0;
                min_reg[i] <= MIN_W'(CAL_MIN_INIT);
                max_reg[i] <= '0;
            end
            sum_reg       <= '0;
            cnt_reg       <= '0;
            scan_mask_reg <= '0;
            held_reg      <= '0;
            walk_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            range_reg     <= range_next;
            thr_reg       <= thr_next;
            min_reg       <= min_next;
            max_reg       <= max_next;
            sum_reg       <= sum_next;
            cnt_reg       <= cnt_next;
            scan_mask_reg <= scan_mask_next;
            held_reg      <= held_next;
            walk_reg      <= walk_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_raw_reg  <= res_raw_next;
        res_seen_reg <= res_seen_next;
        res_mask_reg <= res_mask_next;
        res_scl_reg  <= res_scl_next;
        prod_reg     <= prod_next;
        neg_reg      <= neg_next;
        scl_quo_reg  <= scl_quo_next;
        out_raw_reg  <= out_raw_next;
        out_scl_reg  <= out_scl_next;
        out_seen_reg <= out_seen_next;
        out_mask_reg <= out_mask_next;
    end

    assign out_valid       = out_valid_reg;
    assign raw_position    = out_raw_reg;
    assign scaled_position = $signed(out_scl_reg);
    assign line_seen       = out_seen_reg;
    assign hit_mask        = out_mask_reg;

    a_cnt_matches_mask: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == CNT_W'($countones(scan_mask_reg)))
        else $error("hit count disagrees with scan mask");

    a_seen_matches_mask: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_seen_reg == (out_mask_reg != '0)))
        else $error("line_seen disagrees with hit_mask");

    a_div_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == ST_DIV_AVG))
        else $error("divider finished with nobody waiting");

endmodule

`default_nettype wire
